>>> sv/pdw_pkg.sv
`timescale 1ns / 1ps

package pdw_pkg;

  typedef enum logic {
    CMD_CHECK = 1'b0,
    CMD_LOG   = 1'b1
  } cmd_e;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_e;

  typedef struct packed {
    logic       command;
    logic [7:0] packet_id;
    logic [7:0] hops_left;
  } in_item_t;

  typedef struct packed {
    logic needs_repeat;
    logic id_found;
    logic newly_acked;
  } out_item_t;

  // One window entry as it moves from a cell to its older neighbor.
  typedef struct packed {
    logic       valid;
    logic [7:0] id;
    logic       acked;
  } entry_t;

  // A check travelling down the chain, one cell per cycle.
  typedef struct packed {
    logic       active;
    logic [7:0] id;
    logic       found;
    logic       fresh;
  } query_t;

endpackage

>>> sv/packet_id_dedup_window_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_ready_o  in_item_i   (command, packet_id, hops_left)
// out       output     out_valid_o/out_ready_i out_item_o (needs_repeat, id_found, newly_acked)
//
// A log or a zero-hop check has its result registered in the cycle after acceptance.
// A check with nonzero hops walks the row of WINDOW_DEPTH cells one cell per cycle, and its
// result is registered when the query leaves the last cell; one transaction is in work at a time.
// Reset clears the valid and acked bits of every cell at once; there is no clearing pass.
// A result waiting on out_ready_i holds back the next input only until it is taken.

module packet_id_dedup_window_core
  import pdw_pkg::*;
#(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  state_e    state_q;
  state_e    state_d;
  logic      in_accept;
  logic      is_log;
  logic      start_search;
  logic      search_done;
  logic      out_valid_q;
  out_item_t out_item_q;
  query_t    launch_q;
  entry_t    entry_link [WINDOW_DEPTH+1];
  query_t    query_link [WINDOW_DEPTH+1];

  assign in_accept    = in_valid_i && in_ready_o;
  assign is_log       = (in_item_i.command == CMD_LOG);
  assign start_search = in_accept && !is_log && (in_item_i.hops_left != 8'd0);
  assign search_done  = query_link[WINDOW_DEPTH].active;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_search) begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (search_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    case (state_q)
      ST_IDLE:  in_ready_o = !out_valid_q || out_ready_i;
      default:  in_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_q <= '0;
    end else begin
      launch_q.active <= start_search;
      if (start_search) begin
        launch_q.id <= in_item_i.packet_id;
      end
      launch_q.found <= 1'b0;
      launch_q.fresh <= 1'b0;
    end
  end

  // A log enters at the newest cell; every entry moves one cell older and the oldest drops out.
  assign entry_link[0] = '{valid: 1'b1, id: in_item_i.packet_id, acked: 1'b0};
  assign query_link[0] = launch_q;

  for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
    pdw_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (in_accept && is_log),
      .entry_i (entry_link[k]),
      .entry_o (entry_link[k+1]),
      .query_i (query_link[k]),
      .query_o (query_link[k+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((in_accept && !start_search) || search_done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (search_done) begin
      out_item_q.needs_repeat <= !query_link[WINDOW_DEPTH].found;
      out_item_q.id_found     <= query_link[WINDOW_DEPTH].found;
      out_item_q.newly_acked  <= query_link[WINDOW_DEPTH].fresh;
    end else if (in_accept && !start_search) begin
      out_item_q <= '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

>>> sv/pdw_cell.sv
`timescale 1ns / 1ps

module pdw_cell
  import pdw_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   shift_i,
  input  entry_t entry_i,
  output entry_t entry_o,
  input  query_t query_i,
  output query_t query_o
);

  logic       valid_q;
  logic       acked_q;
  logic [7:0] id_q;
  logic       hit;
  query_t     query_d;
  query_t     query_q;

  // Only the newest matching entry is marked: a query already found passes on untouched.
  assign hit = query_i.active && !query_i.found && valid_q && (id_q == query_i.id);

  always_comb begin
    query_d       = query_i;
    query_d.found = query_i.found | hit;
    query_d.fresh = query_i.fresh | (hit & ~acked_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      acked_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= entry_i.valid;
      acked_q <= entry_i.acked;
    end else if (hit) begin
      acked_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      id_q <= entry_i.id;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_q <= '0;
    end else begin
      query_q <= query_d;
    end
  end

  assign entry_o = '{valid: valid_q, id: id_q, acked: acked_q};
  assign query_o = query_q;

endmodule

>>> sim/packet_id_dedup_window_core_test.sv
`timescale 1ns / 1ps

module packet_id_dedup_window_core_test;
  import pdw_pkg::*;

  localparam int WIN_DEPTH = 16;
  localparam int RANDOM_PER_PHASE = 232;
  localparam int HOLD_CYCLES = 150;
  localparam int QUIET_LIMIT = 2000;
  localparam int SEND_GAP_PCT[4] = '{0, 49, 0, 10};
  localparam int TAKE_STALL_PCT[4] = '{0, 0, 49, 10};

  localparam out_item_t NO_ANSWER = 3'b000;
  localparam out_item_t REPEAT_ANSWER = 3'b100;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // Shadow copy of the window.
  logic [7:0] win_id[WIN_DEPTH];
  logic       win_acked[WIN_DEPTH];
  int         win_count = 0;
  int         win_newest = 0;

  out_item_t pending_answers[$];
  out_item_t head_answer;
  stim_row_t directed_rows[$];

  int fail_count = 0;
  int quiet_cycles = 0;
  int send_gap_pct = 0;
  int take_stall_pct = 0;
  int hold_left = 0;
  bit hold_request = 1'b0;

  packet_id_dedup_window_core #(
    .WINDOW_DEPTH(WIN_DEPTH)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Computes the answer to one transaction and updates the shadow window.
  function automatic out_item_t dedup_window_answer(in_item_t it);
    out_item_t res;
    int slot;
    res = '0;
    if (it.command == CMD_LOG) begin
      if (win_count > 0) win_newest = (win_newest + 1) % WIN_DEPTH;
      win_id[win_newest] = it.packet_id;
      win_acked[win_newest] = 1'b0;
      if (win_count < WIN_DEPTH) win_count++;
    end else if (it.hops_left != 8'd0) begin
      res.needs_repeat = 1'b1;
      // Newest first; only the first match is marked.
      for (int k = 0; k < win_count; k++) begin
        slot = (win_newest + WIN_DEPTH - k) % WIN_DEPTH;
        if (!res.id_found && win_id[slot] == it.packet_id) begin
          res.id_found = 1'b1;
          res.needs_repeat = 1'b0;
          res.newly_acked = !win_acked[slot];
          win_acked[slot] = 1'b1;
        end
      end
    end
    return res;
  endfunction

  function automatic in_item_t random_packet(logic [7:0] pool_base);
    in_item_t it;
    it.command = ($urandom_range(0, 99) < 45) ? CMD_LOG : CMD_CHECK;
    // Most IDs come from a pool a little larger than the window, so checks
    // hit live entries and logs push old ones out.
    if ($urandom_range(0, 9) < 7) it.packet_id = 8'(pool_base + $urandom_range(0, 19));
    else it.packet_id = 8'($urandom_range(0, 255));
    it.hops_left = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    return it;
  endfunction

  task automatic add_row(cmd_e cmd, logic [7:0] id, logic [7:0] hops, bit typed,
                         out_item_t want);
    stim_row_t row;
    row.item.command = cmd;
    row.item.packet_id = id;
    row.item.hops_left = hops;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    out_item_t predicted;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    predicted = dedup_window_answer(it);
    pending_answers.push_back(typed ? want : predicted);
  endtask

  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= take_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        $error("result with no transaction pending: %p", out_item);
        fail_count++;
      end else begin
        head_answer = pending_answers.pop_front();
        if (out_item.needs_repeat !== head_answer.needs_repeat) begin
          $error("needs_repeat: expected %0b, got %0b", head_answer.needs_repeat,
                 out_item.needs_repeat);
          fail_count++;
        end
        if (out_item.id_found !== head_answer.id_found) begin
          $error("id_found: expected %0b, got %0b", head_answer.id_found, out_item.id_found);
          fail_count++;
        end
        if (out_item.newly_acked !== head_answer.newly_acked) begin
          $error("newly_acked: expected %0b, got %0b", head_answer.newly_acked,
                 out_item.newly_acked);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [7:0] pool_base;

    add_row(CMD_CHECK, 8'h00, 8'h01, 1'b1, REPEAT_ANSWER);
    add_row(CMD_CHECK, 8'hFF, 8'hFF, 1'b1, REPEAT_ANSWER);
    add_row(CMD_CHECK, 8'h00, 8'h00, 1'b1, NO_ANSWER);
    add_row(CMD_LOG,   8'h00, 8'h00, 1'b1, NO_ANSWER);
    add_row(CMD_LOG,   8'hFF, 8'hFF, 1'b1, NO_ANSWER);
    add_row(CMD_CHECK, 8'hFF, 8'h01, 1'b0, NO_ANSWER);
    add_row(CMD_CHECK, 8'hFF, 8'h80, 1'b0, NO_ANSWER);
    add_row(CMD_CHECK, 8'h00, 8'hFF, 1'b0, NO_ANSWER);
    // A zero hop count answers nothing even for an ID that is present.
    add_row(CMD_CHECK, 8'h00, 8'h00, 1'b1, NO_ANSWER);
    add_row(CMD_CHECK, 8'h5A, 8'h7F, 1'b0, NO_ANSWER);
    add_row(CMD_LOG,   8'hA5, 8'h00, 1'b1, NO_ANSWER);
    add_row(CMD_LOG,   8'h5A, 8'h55, 1'b1, NO_ANSWER);
    add_row(CMD_LOG,   8'h5A, 8'hAA, 1'b1, NO_ANSWER);
    add_row(CMD_CHECK, 8'h5A, 8'h02, 1'b0, NO_ANSWER);
    add_row(CMD_CHECK, 8'h5A, 8'h02, 1'b0, NO_ANSWER);
    add_row(CMD_CHECK, 8'hA5, 8'h40, 1'b0, NO_ANSWER);
    add_row(CMD_CHECK, 8'h01, 8'h01, 1'b0, NO_ANSWER);
    add_row(CMD_LOG,   8'h80, 8'h01, 1'b1, NO_ANSWER);
    add_row(CMD_CHECK, 8'h80, 8'h00, 1'b1, NO_ANSWER);
    add_row(CMD_CHECK, 8'h80, 8'h10, 1'b0, NO_ANSWER);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int p = 0; p < 4; p++) begin
      send_gap_pct = SEND_GAP_PCT[p];
      take_stall_pct = TAKE_STALL_PCT[p];
      pool_base = 8'($urandom_range(0, 255));
      // In the first phase the receiver holds off for a long stretch while
      // the sender keeps offering, so the block backs up.
      if (p == 0) hold_request = 1'b1;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        send_item(random_packet(pool_base), 1'b0, NO_ANSWER);
      end
    end
    in_valid <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (WIN_DEPTH + 8) @(posedge clk);

    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
